// ----- rtl/lcf_pkg.sv -----
`timescale 1ns / 1ps

package lcf_pkg;

    localparam int LED_COUNT  = 4;
    localparam int FADE_STEPS = 21;

    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int CHANNELS  = 3;
    localparam int CMD_W     = 3;
    localparam int LED_NUM_W = 2;
    localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int STEP_W    = 5;

    // product of a signed channel difference and the step
    localparam int PROD_W = CHAN_W + 1 + STEP_W + 1;
    localparam int MAG_W  = PROD_W - 2;

    // floor(n / FADE_STEPS) as (n * RECIP) >> DIV_SHIFT, exact for n * FADE_STEPS < 2**DIV_SHIFT
    localparam int DIV_SHIFT = 18;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << DIV_SHIFT) + FADE_STEPS - 1) / FADE_STEPS);

    localparam int OPQ_DEPTH   = 2;
    localparam int OPQ_PTR_W   = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(LED_COUNT - 1);
    localparam logic [STEP_W-1:0]    STEP_MAX = STEP_W'(FADE_STEPS);

    // input commands
    localparam logic [CMD_W-1:0] CMD_SET_ONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ALL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSTANT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FADE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    // decoded operations held in the op queue
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_SET_ONE = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_ALL = 3'd1;
    localparam logic [OP_W-1:0] OP_INSTANT = 3'd2;
    localparam logic [OP_W-1:0] OP_FADE    = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [LED_IDX_W-1:0] idx;
        color_t               color;
    } op_t;

    typedef struct packed {
        logic [LED_IDX_W-1:0] led;
        color_t               color;
        logic                 last;
    } res_t;

endpackage

// ----- rtl/lcf_front.sv -----
`timescale 1ns / 1ps

module lcf_front
    import lcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CMD_W-1:0]     command,
    input  logic [LED_NUM_W-1:0] led_index,
    input  color_t               color_in,
    input  logic                 deq,
    output logic                 q_empty,
    output op_t                  q_head
);

    op_t                  mem_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_PTR_W:0]   count_reg, count_next;

    op_t  dec_op;
    logic dec_keep;
    logic do_wr;
    logic do_rd;

    // classify; unknown commands and out-of-range indexes are dropped here
    always_comb
    begin
        dec_op.idx   = LED_IDX_W'(led_index);
        dec_op.color = color_in;
        dec_op.op    = OP_SET_ONE;
        dec_keep     = 1'b1;
        case (command)
            CMD_SET_ONE:
            begin
                dec_op.op = OP_SET_ONE;
                dec_keep  = (int'(led_index) < LED_COUNT);
            end
            CMD_SET_ALL: dec_op.op = OP_SET_ALL;
            CMD_INSTANT: dec_op.op = OP_INSTANT;
            CMD_FADE:    dec_op.op = OP_FADE;
            CMD_TICK:    dec_op.op = OP_TICK;
            default:     dec_keep  = 1'b0;
        endcase
    end

    assign full    = (count_reg == (OPQ_PTR_W+1)'(OPQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = mem_reg[rd_ptr_reg];

    assign do_wr = push && !full && dec_keep;
    assign do_rd = deq && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= dec_op;
        end
    end

endmodule

// ----- rtl/lcf_outq.sv -----
`timescale 1ns / 1ps

module lcf_outq
    import lcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  res_t                  wr_word,
    input  logic                  pop,
    output logic                  empty,
    output res_t                  head,
    output logic [OUTQ_CNT_W-1:0] count
);

    res_t                  mem_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    // writer only pushes against a free slot it has reserved
    assign do_wr = wr_en && (count_reg != OUTQ_CNT_W'(OUTQ_DEPTH));
    assign do_rd = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

// ----- rtl/lcf_back.sv -----
`timescale 1ns / 1ps

module lcf_back
    import lcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  op_t                   q_head,
    output logic                  deq,
    output logic                  res_wr,
    output res_t                  res_word,
    input  logic [OUTQ_CNT_W-1:0] outq_count
);

    // colour stores
    color_t target_reg [LED_COUNT];
    color_t target_next [LED_COUNT];
    color_t shown_reg  [LED_COUNT];
    color_t shown_next [LED_COUNT];
    color_t start_reg  [LED_COUNT];
    color_t start_next [LED_COUNT];

    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 pending_reg, pending_next;

    // LED sweep control
    logic                 run_reg, run_next;
    logic                 instant_reg, instant_next;
    logic                 restart_reg, restart_next;
    logic [LED_IDX_W-1:0] cnt_reg, cnt_next;
    logic [STEP_W-1:0]    run_step_reg, run_step_next;
    color_t               run_color_reg, run_color_next;

    // blend stage
    logic                       sb_valid_reg, sb_valid_next;
    logic                       sb_instant_reg, sb_instant_next;
    logic                       sb_last_reg, sb_last_next;
    logic [LED_IDX_W-1:0]       sb_idx_reg, sb_idx_next;
    color_t                     sb_color_reg, sb_color_next;
    logic signed [PROD_W-1:0]   sb_prod_reg [CHANNELS];
    logic signed [PROD_W-1:0]   sb_prod_next [CHANNELS];
    logic [CHAN_W-1:0]          sb_base_reg [CHANNELS];
    logic [CHAN_W-1:0]          sb_base_next [CHANNELS];

    logic                       issue;
    logic [STEP_W-1:0]          step_eff;
    color_t                     from_col;
    color_t                     to_col;
    color_t                     mixed;
    logic signed [CHAN_W:0]     diff;
    logic signed [STEP_W:0]     step_s;
    logic                       neg;
    logic [PROD_W-1:0]          mag_full;
    logic [MAG_W-1:0]           num;
    logic [MAG_W+RECIP_W-1:0]   quo_full;
    logic [CHAN_W-1:0]          quo;

    // stage B: divide by the fade length (floor) and add back the start colour
    always_comb
    begin
        mixed    = '0;
        neg      = 1'b0;
        mag_full = '0;
        num      = '0;
        quo_full = '0;
        quo      = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            neg      = sb_prod_reg[c][PROD_W-1];
            mag_full = neg ? PROD_W'(-sb_prod_reg[c]) : PROD_W'(sb_prod_reg[c]);
            num      = mag_full[MAG_W-1:0] + (neg ? MAG_W'(FADE_STEPS - 1) : MAG_W'(0));
            quo_full = (MAG_W+RECIP_W)'(num) * (MAG_W+RECIP_W)'(RECIP);
            quo      = quo_full[DIV_SHIFT +: CHAN_W];
            mixed[c*CHAN_W +: CHAN_W] = neg ? (sb_base_reg[c] - quo) : (sb_base_reg[c] + quo);
        end
    end

    assign res_wr         = sb_valid_reg;
    assign res_word.led   = sb_idx_reg;
    assign res_word.color = sb_instant_reg ? sb_color_reg : mixed;
    assign res_word.last  = sb_last_reg;

    // a slot in the result queue is reserved for the word in stage B
    assign issue = run_reg &&
                   ((int'(outq_count) + int'(sb_valid_reg)) < OUTQ_DEPTH);

    always_comb
    begin
        target_next     = target_reg;
        shown_next      = shown_reg;
        start_next      = start_reg;
        step_next       = step_reg;
        pending_next    = pending_reg;
        run_next        = run_reg;
        instant_next    = instant_reg;
        restart_next    = restart_reg;
        cnt_next        = cnt_reg;
        run_step_next   = run_step_reg;
        run_color_next  = run_color_reg;
        sb_valid_next   = issue;
        sb_instant_next = sb_instant_reg;
        sb_last_next    = sb_last_reg;
        sb_idx_next     = sb_idx_reg;
        sb_color_next   = sb_color_reg;
        sb_prod_next    = sb_prod_reg;
        sb_base_next    = sb_base_reg;
        deq             = 1'b0;
        step_eff        = step_reg;
        from_col        = '0;
        to_col          = '0;
        diff            = '0;
        step_s          = '0;

        if (sb_valid_reg)
        begin
            shown_next[sb_idx_reg] = res_word.color;
        end

        // stage A: one LED per cycle while the result queue has a slot free
        if (issue)
        begin
            sb_idx_next     = cnt_reg;
            sb_last_next    = (cnt_reg == LAST_LED);
            sb_instant_next = instant_reg;
            sb_color_next   = run_color_reg;
            if (instant_reg)
            begin
                target_next[cnt_reg] = run_color_reg;
                shown_next[cnt_reg]  = run_color_reg;
                start_next[cnt_reg]  = run_color_reg;
            end
            else
            begin
                from_col = restart_reg ? shown_reg[cnt_reg] : start_reg[cnt_reg];
                to_col   = target_reg[cnt_reg];
                if (restart_reg)
                begin
                    start_next[cnt_reg] = shown_reg[cnt_reg];
                end
                step_s = $signed({1'b0, run_step_reg});
                for (int c = 0; c < CHANNELS; c++)
                begin
                    diff = $signed({1'b0, to_col[c*CHAN_W +: CHAN_W]})
                         - $signed({1'b0, from_col[c*CHAN_W +: CHAN_W]});
                    sb_prod_next[c] = diff * step_s;
                    sb_base_next[c] = from_col[c*CHAN_W +: CHAN_W];
                end
            end
            if (cnt_reg == LAST_LED)
            begin
                run_next = 1'b0;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        // next op starts once the previous sweep has fully drained
        if (!run_reg && !sb_valid_reg && !q_empty)
        begin
            deq = 1'b1;
            case (q_head.op)
                OP_SET_ONE:
                begin
                    target_next[q_head.idx] = q_head.color;
                end
                OP_SET_ALL:
                begin
                    for (int i = 0; i < LED_COUNT; i++)
                    begin
                        target_next[i] = q_head.color;
                    end
                end
                OP_INSTANT:
                begin
                    run_next       = 1'b1;
                    instant_next   = 1'b1;
                    cnt_next       = '0;
                    run_color_next = q_head.color;
                end
                OP_FADE:
                begin
                    pending_next = 1'b1;
                end
                OP_TICK:
                begin
                    step_eff     = pending_reg ? '0 : step_reg;
                    restart_next = pending_reg;
                    pending_next = 1'b0;
                    if (step_eff <= STEP_MAX)
                    begin
                        run_next      = 1'b1;
                        instant_next  = 1'b0;
                        cnt_next      = '0;
                        run_step_next = step_eff;
                        step_next     = step_eff + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                target_reg[i] <= '0;
                shown_reg[i]  <= '0;
                start_reg[i]  <= '0;
            end
            step_reg     <= STEP_MAX;
            pending_reg  <= 1'b0;
            run_reg      <= 1'b0;
            instant_reg  <= 1'b0;
            restart_reg  <= 1'b0;
            cnt_reg      <= '0;
            sb_valid_reg <= 1'b0;
        end
        else
        begin
            target_reg   <= target_next;
            shown_reg    <= shown_next;
            start_reg    <= start_next;
            step_reg     <= step_next;
            pending_reg  <= pending_next;
            run_reg      <= run_next;
            instant_reg  <= instant_next;
            restart_reg  <= restart_next;
            cnt_reg      <= cnt_next;
            sb_valid_reg <= sb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_step_reg   <= run_step_next;
        run_color_reg  <= run_color_next;
        sb_instant_reg <= sb_instant_next;
        sb_last_reg    <= sb_last_next;
        sb_idx_reg     <= sb_idx_next;
        sb_color_reg   <= sb_color_next;
        sb_prod_reg    <= sb_prod_next;
        sb_base_reg    <= sb_base_next;
    end

endmodule

// ----- rtl/led_color_fade_engine.sv -----
// LED colour fade engine: target, shown and start colours for a row of RGB LEDs.
// Input channel (queue style): present command, led_index and color_in with push;
// the word is taken on a clock edge with push high and full low. A two-word op
// queue sits behind the input, so commands are taken while a sweep is running.
// Result channel: while empty is low the oldest result word is on led_number,
// color_out and last_of_frame; pop takes it. An instant set, or a frame tick up to
// the fade length, gives one word per LED, LED 0 first, last_of_frame on the final
// one; an idle tick past the fade length and other commands give none.
// Execution: a tick or instant set holds the execution side for a start step, then
// passes each LED in turn through the multiply stage and the divide-and-add stage;
// the next command waits until the last LED has left the divide-and-add stage.
// Other commands only take the start step. The first result word goes through the
// op queue, the start step and the two blend stages before it enters the result queue.
// When the receiver stalls, the result queue fills, the sweep pauses, then the
// op queue fills and full rises; nothing is dropped.
// Reset clears all colours to black, parks the fade step at the fade length with
// no fade pending, and empties both queues.
`timescale 1ns / 1ps

module led_color_fade_engine
    import lcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CMD_W-1:0]     command,
    input  logic [LED_NUM_W-1:0] led_index,
    input  logic [COLOR_W-1:0]   color_in,
    output logic                 empty,
    input  logic                 pop,
    output logic [LED_NUM_W-1:0] led_number,
    output logic [COLOR_W-1:0]   color_out,
    output logic                 last_of_frame
);

    logic                  q_empty;
    op_t                   q_head;
    logic                  deq;
    logic                  res_wr;
    res_t                  res_word;
    res_t                  head;
    logic [OUTQ_CNT_W-1:0] outq_count;

    lcf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .led_index (led_index),
        .color_in  (color_in),
        .deq       (deq),
        .q_empty   (q_empty),
        .q_head    (q_head)
    );

    lcf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .deq        (deq),
        .res_wr     (res_wr),
        .res_word   (res_word),
        .outq_count (outq_count)
    );

    lcf_outq u_outq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_word (res_word),
        .pop     (pop),
        .empty   (empty),
        .head    (head),
        .count   (outq_count)
    );

    assign led_number    = LED_NUM_W'(head.led);
    assign color_out     = head.color;
    assign last_of_frame = head.last;

endmodule

// ----- rtl/lcf_checker.sv -----
`timescale 1ns / 1ps

module lcf_checker
    import lcf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 empty,
    input logic                 pop,
    input logic [LED_NUM_W-1:0] led_number,
    input logic [COLOR_W-1:0]   color_out,
    input logic                 last_of_frame
);

    // last flag goes with the final LED and only with it
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_of_frame == (led_number == LED_NUM_W'(LED_COUNT - 1))))
        else $error("last_of_frame does not match led_number");

    // within a frame LED numbers climb by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_of_frame) |=>
            (empty || (led_number == LED_NUM_W'($past(led_number) + 1'b1))))
        else $error("result word out of sequence");

    // a new frame starts at LED 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last_of_frame) |=> (empty || (led_number == '0)))
        else $error("frame does not start at LED 0");

    // stalled head word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(led_number) && $stable(color_out) && $stable(last_of_frame)))
        else $error("result word changed while stalled");

endmodule

bind led_color_fade_engine lcf_checker u_lcf_checker (.*);

// ----- tb/fade_checker.sv -----
`timescale 1ns / 1ps

module fade_checker
    import lcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [CMD_W-1:0]     command,
    input  logic [LED_NUM_W-1:0] led_index,
    input  logic [COLOR_W-1:0]   color_in,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [LED_NUM_W-1:0] led_number,
    input  logic [COLOR_W-1:0]   color_out,
    input  logic                 last_of_frame,
    output int                   fail_count,
    output int                   outstanding
);

    color_t      target_c [LED_COUNT];
    color_t      shown_c  [LED_COUNT];
    color_t      start_c  [LED_COUNT];
    int unsigned fade_pos;
    bit          fade_armed;
    res_t        frame_q [$];
    int          errors;

    initial
    begin
        errors      = 0;
        fail_count  = 0;
        outstanding = 0;
    end

    // a + floor((b - a) * s / FADE_STEPS), rounding towards minus infinity
    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] b,
                                                     input int s);
        int diff;
        int prod;
        int quo;
        diff = int'(b) - int'(a);
        prod = diff * s;
        if (prod >= 0)
            quo = prod / FADE_STEPS;
        else
            quo = -((-prod + FADE_STEPS - 1) / FADE_STEPS);
        return CHAN_W'(int'(a) + quo);
    endfunction

    function automatic color_t blend_colour(input color_t a, input color_t b, input int s);
        color_t r;
        for (int ch = 0; ch < CHANNELS; ch++)
            r[ch*CHAN_W +: CHAN_W] = blend_chan(a[ch*CHAN_W +: CHAN_W],
                                                b[ch*CHAN_W +: CHAN_W], s);
        return r;
    endfunction

    task automatic queue_frame();
        res_t w;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            w.led   = LED_IDX_W'(i);
            w.color = shown_c[i];
            w.last  = (i == LED_COUNT - 1);
            frame_q.push_back(w);
        end
    endtask

    task automatic apply_word(input logic [CMD_W-1:0] cmd,
                              input logic [LED_NUM_W-1:0] idx,
                              input color_t col);
        case (cmd)
            CMD_SET_ONE:
                if (int'(idx) < LED_COUNT)
                    target_c[idx] = col;
            CMD_SET_ALL:
                for (int i = 0; i < LED_COUNT; i++)
                    target_c[i] = col;
            CMD_INSTANT:
            begin
                for (int i = 0; i < LED_COUNT; i++)
                begin
                    target_c[i] = col;
                    shown_c[i]  = col;
                    start_c[i]  = col;
                end
                queue_frame();
            end
            CMD_FADE:
                fade_armed = 1'b1;
            CMD_TICK:
            begin
                if (fade_armed)
                begin
                    for (int i = 0; i < LED_COUNT; i++)
                        start_c[i] = shown_c[i];
                    fade_pos   = 0;
                    fade_armed = 1'b0;
                end
                // past the fade length with nothing pending: idle tick, no words
                if (fade_pos <= FADE_STEPS)
                begin
                    for (int i = 0; i < LED_COUNT; i++)
                        shown_c[i] = blend_colour(start_c[i], target_c[i], fade_pos);
                    fade_pos++;
                    queue_frame();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t w;
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                target_c[i] = '0;
                shown_c[i]  = '0;
                start_c[i]  = '0;
            end
            fade_pos   = FADE_STEPS;
            fade_armed = 1'b0;
            frame_q.delete();
        end
        else
        begin
            if (push && !full)
                apply_word(command, led_index, color_in);
            if (pop && !empty)
            begin
                if (frame_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected word: led %0d colour %06h last %0b",
                                 led_number, color_out, last_of_frame);
                    errors++;
                end
                else
                begin
                    w = frame_q.pop_front();
                    if (w.led !== led_number || w.color !== color_out ||
                        w.last !== last_of_frame)
                    begin
                        if (errors < 10)
                            $display("mismatch (exp/got): led %0d/%0d colour %06h/%06h last %0b/%0b",
                                     w.led, led_number, w.color, color_out,
                                     w.last, last_of_frame);
                        errors++;
                    end
                end
            end
        end
        fail_count  = errors;
        outstanding = frame_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lcf_pkg::*;

    localparam int          RANDOM_ITEMS = 130;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [CMD_W-1:0]     command;
    logic [LED_NUM_W-1:0] led_index;
    logic [COLOR_W-1:0]   color_in;
    logic                 empty;
    logic                 pop;
    logic [LED_NUM_W-1:0] led_number;
    logic [COLOR_W-1:0]   color_out;
    logic                 last_of_frame;
    int                   fail_count;
    int                   outstanding;

    bit                   hold_req;
    bit                   steady;
    int                   sent;

    led_color_fade_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .led_index     (led_index),
        .color_in      (color_in),
        .empty         (empty),
        .pop           (pop),
        .led_number    (led_number),
        .color_out     (color_out),
        .last_of_frame (last_of_frame)
    );

    fade_checker i_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .led_index     (led_index),
        .color_in      (color_in),
        .empty         (empty),
        .pop           (pop),
        .led_number    (led_number),
        .color_out     (color_out),
        .last_of_frame (last_of_frame),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        command   = CMD_SET_ONE;
        led_index = '0;
        color_in  = '0;
        hold_req  = 1'b0;
        steady    = 1'b0;
        sent      = 0;
    end

    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic color_t pick_colour();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {($urandom_range(0, 1) ? 8'hFF : 8'h00),
                       ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                       ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [LED_NUM_W-1:0] pick_led();
        return LED_NUM_W'($urandom_range(0, LED_COUNT - 1));
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic [LED_NUM_W-1:0] idx,
                             input color_t col);
        int unsigned n;
        @(negedge clk);
        push      <= 1'b1;
        command   <= cmd;
        led_index <= idx;
        color_in  <= col;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (cmd <= CMD_TICK)
            sent++;
        n = steady ? 0 : gap_len();
        repeat (n)
        begin
            @(negedge clk);
            push      <= 1'b0;
            command   <= CMD_W'($urandom);
            led_index <= LED_NUM_W'($urandom);
            color_in  <= COLOR_W'($urandom);
        end
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd);
        send_word(cmd, pick_led(), pick_colour());
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // receiver: random pops, one long hold-off on request
    initial
    begin
        int unsigned burst;
        int unsigned rest;
        bit          held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk) pop <= 1'b0;
            end
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
            repeat (burst) @(negedge clk) pop <= 1'b1;
            rest = gap_len();
            repeat (rest) @(negedge clk) pop <= 1'b0;
        end
    end

    initial
    begin
        int unsigned n;
        while (n < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned n;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset-state tick at the fade length, then an idle tick
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_word(CMD_SET_ONE, 2'd0, 24'hFFFFFF);
        send_word(CMD_SET_ONE, 2'd1, 24'h000000);
        send_word(CMD_SET_ONE, 2'd2, 24'hFF00FF);
        send_word(CMD_SET_ONE, 2'd3, 24'h00FF00);
        for (int c = CMD_TICK + 1; c < (1 << CMD_W); c++)
            send_cmd(CMD_W'(c));
        send_cmd(CMD_FADE);
        repeat (3) send_cmd(CMD_TICK);
        send_word(CMD_INSTANT, 2'd3, 24'hFFFFFF);
        send_word(CMD_SET_ALL, 2'd0, 24'h000000);
        send_cmd(CMD_FADE);
        send_cmd(CMD_TICK);
        // restart mid-fade
        send_cmd(CMD_FADE);
        send_cmd(CMD_TICK);
        send_word(CMD_INSTANT, 2'd0, 24'h000000);
        send_word(CMD_SET_ONE, 2'd3, 24'hFFFFFF);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS / 2)
                hold_req = 1'b1;
            steady = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    if ($urandom_range(0, 1))
                        send_cmd(CMD_SET_ALL);
                    n = $urandom_range(0, 4);
                    repeat (n) send_cmd(CMD_SET_ONE);
                    send_cmd(CMD_FADE);
                    // now and then run the fade out past its end
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 24)
                                                    : $urandom_range(1, 8);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            send_cmd(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)));
                        send_cmd(CMD_TICK);
                    end
                end
                6:
                begin
                    send_cmd(CMD_INSTANT);
                    n = $urandom_range(0, 3);
                    repeat (n) send_cmd(CMD_TICK);
                end
                7, 8:
                    send_cmd(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)));
                default:
                    send_cmd(CMD_TICK);
            endcase
            if (sent >= RANDOM_ITEMS / 4 && sent < RANDOM_ITEMS / 4 + 6)
                drain();
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
